// ===== sv/aipd_pkg.sv =====
// Shared constants, register indexes and state encoding of the impact peak detector.
package aipd_pkg;

  localparam int TIME_BITS_DEF       = 48;
  localparam int FLOOR_FRAC_BITS_DEF = 24;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam int MUL_B_BITS     = 24;
  localparam int MUL_DIGIT_BITS = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_GAIN   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MINIMUM_PEAK     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_FLOOR    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_GAIN        = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTHING_FACTOR = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_TICKS    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_REFRACTORY_TICKS = 3'd6;

  localparam logic [15:0] THRESHOLD_GAIN_RST   = 16'd1024;
  localparam logic [15:0] MINIMUM_PEAK_RST     = 16'd3277;
  localparam logic [15:0] INITIAL_FLOOR_RST    = 16'd328;
  localparam logic [15:0] CLIP_GAIN_RST        = 16'd512;
  localparam logic [23:0] SMOOTHING_FACTOR_RST = 24'd350;
  localparam logic [23:0] CONFIRM_TICKS_RST    = 24'd240;
  localparam logic [23:0] REFRACTORY_TICKS_RST = 24'd24000;

  localparam logic [15:0] FULL_SCALE = 16'd32768;

  localparam logic KIND_IMPACT = 1'b0;
  localparam logic KIND_ERROR  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPEN1,
    S_OPEN2,
    S_THR,
    S_THR_WAIT,
    S_DECIDE,
    S_ONSET2,
    S_CLIP_WAIT,
    S_DIFF,
    S_SMOOTH,
    S_SMOOTH_WAIT,
    S_UPD,
    S_FLUSH
  } aipd_state_e;

endpackage

// ===== sv/aipd_ser_mul.sv =====
// Digit-serial shift-and-add multiplier, one multiplier digit per cycle.
module aipd_ser_mul #(
  parameter int A_BITS = aipd_pkg::FLOOR_FRAC_BITS_DEF + 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [A_BITS-1:0]                    a_i,
  input  logic [aipd_pkg::MUL_B_BITS-1:0]      b_i,
  output logic                                 done_o,
  output logic [A_BITS+aipd_pkg::MUL_B_BITS-1:0] prod_o
);
  import aipd_pkg::*;

  localparam int PW     = A_BITS + MUL_B_BITS;
  localparam int DIGITS = MUL_B_BITS / MUL_DIGIT_BITS;
  localparam int CW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic                  busy_q;
  logic                  done_q;
  logic [CW-1:0]         cnt_q;
  logic [A_BITS-1:0]     a_q;
  logic [MUL_B_BITS-1:0] b_q;
  logic [PW-1:0]         acc_q;
  logic [A_BITS+MUL_DIGIT_BITS-1:0] part;

  assign part = a_q * b_q[MUL_B_BITS-1 -: MUL_DIGIT_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(DIGITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << MUL_DIGIT_BITS) + PW'(part);
      b_q   <= b_q << MUL_DIGIT_BITS;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== sv/aipd_out_fifo.sv =====
// Two-entry result queue that decouples the sequencer from the output channel.
module aipd_out_fifo #(
  parameter int WIDTH = 2 * aipd_pkg::TIME_BITS_DEF + 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] out_data_o
);
  import aipd_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign full_o      = count_q == 2'd2;
  assign out_valid_o = count_q != 2'd0;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== sv/adaptive_impact_peak_detector.sv =====
// Top level of the adaptive impact peak detector with refractory period.
// A new sample is accepted only in the idle state, once the previous sample has finished the path
// it took and its results are flushed into the result queue, so samples are never overlapped.
// The time per sample depends on the path taken and on the digit-serial multiplier (six 4-bit
// digits) shared by the threshold, clip and smoothing products; a full result queue stalls the
// flush. Reset: asynchronous, active low.
module adaptive_impact_peak_detector #(
  parameter int TIME_BITS       = aipd_pkg::TIME_BITS_DEF,
  parameter int FLOOR_FRAC_BITS = aipd_pkg::FLOOR_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aipd_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [aipd_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [15:0]                pcm_sample_i,
  input  logic [TIME_BITS-1:0]              tick_time_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              event_kind_o,
  output logic [TIME_BITS-1:0]              strike_tick_o,
  output logic [TIME_BITS-1:0]              confirm_tick_o,
  output logic [15:0]                       peak_level_o,
  output logic [15:0]                       floor_at_onset_o,
  output logic [15:0]                       threshold_at_onset_o,
  output logic                              last_of_run_o
);
  import aipd_pkg::*;

  localparam int F  = FLOOR_FRAC_BITS;
  localparam int NW = F + 1;              // noise level, Q1.F
  localparam int PW = NW + MUL_B_BITS;    // multiplier product
  localparam int TW = TIME_BITS;
  localparam int RW = 1 + 2 * TW + 48;    // kind, two ticks, three levels
  localparam logic [NW-1:0] ONE_F = NW'(1) << F;
  localparam logic [TW-1:0] TMAX  = '1;

  // Saturating addition of a tick count to a timestamp.
  function automatic logic [TW-1:0] time_add(input logic [TW-1:0] a, input logic [23:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + (TW + 1)'(b);
    return s[TW] ? TMAX : s[TW-1:0];
  endfunction

  // Configuration registers.
  logic [15:0] thr_gain_q, min_peak_q, init_floor_q, clip_gain_q;
  logic [23:0] smooth_q, confirm_q, refr_q;

  // Detector state.
  aipd_state_e state_q, state_d;
  logic [NW-1:0] noise_q, noise_d;
  logic          open_q, open_d;
  logic [TW-1:0] strike_q, strike_d;
  logic [15:0]   peak_q, peak_d, hfloor_q, hfloor_d, hthr_q, hthr_d;
  logic [TW-1:0] deadline_q, deadline_d, rend_q, rend_d;
  logic          armed_q, armed_d, seen_q, seen_d;
  logic [TW-1:0] prev_q, prev_d;

  // Current sample and result staging.
  logic [15:0]   mag_q, mag_d;
  logic [TW-1:0] t_q, t_d;
  logic [RW-1:0] res_q [2];
  logic [RW-1:0] res_d [2];
  logic [1:0]    n_q, n_d;
  logic [1:0]    idx_q, idx_d;
  logic [NW-1:0] diff_q, diff_d;
  logic          up_q, up_d;

  logic          in_acc;
  logic          err_now;
  logic [15:0]   mag_in;
  logic          mul_start, mul_done;
  logic [NW-1:0] mul_a;
  logic [MUL_B_BITS-1:0] mul_b;
  logic [PW-1:0] mul_prod;
  logic          fifo_push, fifo_full;
  logic [RW:0]   fifo_in, fifo_out;

  logic [NW-1:0] init_q_f, basis;
  logic [15:0]   init_c;
  logic          above, free, due;
  logic [PW-1:0] thr_full, limit, x_full, x_sel;
  logic [15:0]   thr_c;
  logic [NW-1:0] x_n;
  logic [PW:0]   step;
  logic [NW:0]   sum_up;
  logic [RW-1:0] emit_rec;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign err_now = seen_q && (tick_time_i <= prev_q);
  assign mag_in  = pcm_sample_i[15] ? (~pcm_sample_i + 16'd1) : pcm_sample_i;

  assign init_c   = (init_floor_q > FULL_SCALE) ? FULL_SCALE : init_floor_q;
  assign init_q_f = NW'(init_c) << (F - 15);
  assign basis    = (noise_q > init_q_f) ? noise_q : init_q_f;

  // Threshold test against the product of floor and gain, exact in the wide domain.
  assign above    = (mag_q >= min_peak_q) && ((PW'(mag_q) << (F - 7)) >= mul_prod);
  assign free     = !armed_q || (t_q >= rend_q);
  assign due      = t_q >= deadline_q;
  assign thr_full = mul_prod >> (F - 7);
  always_comb begin
    thr_c = 16'hFFFF;
    if (thr_full < PW'(min_peak_q)) thr_c = min_peak_q;
    else if (thr_full <= PW'(16'hFFFF)) thr_c = thr_full[15:0];
  end

  // Clip the new magnitude to the limit derived from the floor.
  assign limit  = mul_prod >> 8;
  assign x_full = PW'(mag_q) << (F - 15);
  assign x_sel  = (x_full > limit) ? limit : x_full;
  assign x_n    = x_sel[NW-1:0];

  // Floor step, rounded toward minus infinity in both directions.
  assign step   = up_q ? ((PW + 1)'(mul_prod) >> 24)
                       : (((PW + 1)'(mul_prod) + (PW + 1)'(24'hFFFFFF)) >> 24);
  assign sum_up = (NW + 1)'(noise_q) + step[NW:0];

  assign emit_rec = {KIND_IMPACT, strike_q, t_q, peak_q, hfloor_q, hthr_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (err_now) state_d = S_FLUSH;
          else if (open_q) state_d = S_OPEN1;
          else state_d = S_THR;
        end
      end
      S_OPEN1:       state_d = due ? S_THR : S_OPEN2;
      S_OPEN2:       state_d = S_FLUSH;
      S_THR:         state_d = S_THR_WAIT;
      S_THR_WAIT:    if (mul_done) state_d = S_DECIDE;
      S_DECIDE:      state_d = (free && above) ? S_ONSET2 : S_CLIP_WAIT;
      S_ONSET2:      state_d = S_FLUSH;
      S_CLIP_WAIT:   if (mul_done) state_d = S_DIFF;
      S_DIFF:        state_d = S_SMOOTH;
      S_SMOOTH:      state_d = S_SMOOTH_WAIT;
      S_SMOOTH_WAIT: if (mul_done) state_d = S_UPD;
      S_UPD:         state_d = S_FLUSH;
      S_FLUSH: begin
        if (n_q == 2'd0) state_d = S_IDLE;
        else if (!fifo_full && (idx_q == n_q - 2'd1)) state_d = S_IDLE;
      end
      default:       state_d = S_IDLE;
    endcase
  end

  // Handshake and multiplier control.
  always_comb begin
    in_stall_o = state_q != S_IDLE;
    mul_start  = 1'b0;
    mul_a      = noise_q;
    mul_b      = MUL_B_BITS'(thr_gain_q);
    fifo_push  = 1'b0;
    unique case (state_q)
      S_THR: mul_start = 1'b1;
      S_DECIDE: begin
        mul_start = !(free && above);
        mul_a     = basis;
        mul_b     = MUL_B_BITS'(clip_gain_q);
      end
      S_SMOOTH: begin
        mul_start = 1'b1;
        mul_a     = diff_q;
        mul_b     = smooth_q;
      end
      S_FLUSH: fifo_push = (n_q != 2'd0) && !fifo_full;
      default: ;
    endcase
  end

  assign fifo_in = {res_q[idx_q[0]], idx_q == n_q - 2'd1};

  // Datapath next values.
  always_comb begin
    noise_d    = noise_q;
    open_d     = open_q;
    strike_d   = strike_q;
    peak_d     = peak_q;
    hfloor_d   = hfloor_q;
    hthr_d     = hthr_q;
    deadline_d = deadline_q;
    rend_d     = rend_q;
    armed_d    = armed_q;
    seen_d     = seen_q;
    prev_d     = prev_q;
    mag_d      = mag_q;
    t_d        = t_q;
    res_d[0]   = res_q[0];
    res_d[1]   = res_q[1];
    n_d        = n_q;
    idx_d      = idx_q;
    diff_d     = diff_q;
    up_d       = up_q;
    unique case (state_q)
      S_IDLE: begin
        if (cfg_we_i && (cfg_index_i == REG_INITIAL_FLOOR) && !seen_q) begin
          noise_d = NW'(((cfg_data_i[15:0] > FULL_SCALE) ? FULL_SCALE : cfg_data_i[15:0]))
                    << (F - 15);
        end
        if (in_acc) begin
          mag_d = mag_in;
          t_d   = tick_time_i;
          idx_d = 2'd0;
          if (err_now) begin
            res_d[0] = {KIND_ERROR, {(RW - 1){1'b0}}};
            n_d      = 2'd1;
          end else begin
            n_d    = 2'd0;
            seen_d = 1'b1;
            prev_d = tick_time_i;
          end
        end
      end
      S_OPEN1: begin
        if (due) begin
          res_d[n_q[0]] = emit_rec;
          n_d     = n_q + 2'd1;
          rend_d  = time_add(strike_q, refr_q);
          armed_d = 1'b1;
          open_d  = 1'b0;
        end else if (mag_q > peak_q) begin
          strike_d   = t_q;
          peak_d     = mag_q;
          deadline_d = time_add(t_q, confirm_q);
        end
      end
      S_OPEN2, S_ONSET2: begin
        if (due) begin
          res_d[n_q[0]] = emit_rec;
          n_d     = n_q + 2'd1;
          rend_d  = time_add(strike_q, refr_q);
          armed_d = 1'b1;
          open_d  = 1'b0;
        end
      end
      S_DECIDE: begin
        if (free && above) begin
          open_d     = 1'b1;
          strike_d   = t_q;
          peak_d     = mag_q;
          hfloor_d   = 16'(noise_q >> (F - 15));
          hthr_d     = thr_c;
          deadline_d = time_add(t_q, confirm_q);
        end
      end
      S_DIFF: begin
        up_d   = x_n >= noise_q;
        diff_d = (x_n >= noise_q) ? (x_n - noise_q) : (noise_q - x_n);
      end
      S_UPD: begin
        if (up_q) begin
          noise_d = (sum_up > (NW + 1)'(ONE_F)) ? ONE_F : sum_up[NW-1:0];
        end else begin
          noise_d = (step > (PW + 1)'(noise_q)) ? '0 : (noise_q - step[NW-1:0]);
        end
      end
      S_FLUSH: begin
        if (fifo_push) idx_d = idx_q + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      thr_gain_q   <= THRESHOLD_GAIN_RST;
      min_peak_q   <= MINIMUM_PEAK_RST;
      init_floor_q <= INITIAL_FLOOR_RST;
      clip_gain_q  <= CLIP_GAIN_RST;
      smooth_q     <= SMOOTHING_FACTOR_RST;
      confirm_q    <= CONFIRM_TICKS_RST;
      refr_q       <= REFRACTORY_TICKS_RST;
      noise_q      <= NW'(INITIAL_FLOOR_RST) << (F - 15);
      open_q       <= 1'b0;
      strike_q     <= '0;
      peak_q       <= '0;
      hfloor_q     <= '0;
      hthr_q       <= '0;
      deadline_q   <= '0;
      rend_q       <= '0;
      armed_q      <= 1'b0;
      seen_q       <= 1'b0;
      prev_q       <= '0;
      n_q          <= 2'd0;
      idx_q        <= 2'd0;
    end else begin
      state_q    <= state_d;
      noise_q    <= noise_d;
      open_q     <= open_d;
      strike_q   <= strike_d;
      peak_q     <= peak_d;
      hfloor_q   <= hfloor_d;
      hthr_q     <= hthr_d;
      deadline_q <= deadline_d;
      rend_q     <= rend_d;
      armed_q    <= armed_d;
      seen_q     <= seen_d;
      prev_q     <= prev_d;
      n_q        <= n_d;
      idx_q      <= idx_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_THRESHOLD_GAIN:   thr_gain_q   <= cfg_data_i[15:0];
          REG_MINIMUM_PEAK:     min_peak_q   <= cfg_data_i[15:0];
          REG_INITIAL_FLOOR:    init_floor_q <= cfg_data_i[15:0];
          REG_CLIP_GAIN:        clip_gain_q  <= cfg_data_i[15:0];
          REG_SMOOTHING_FACTOR: smooth_q     <= cfg_data_i;
          REG_CONFIRM_TICKS:    confirm_q    <= cfg_data_i;
          REG_REFRACTORY_TICKS: refr_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers of the sample in flight.
  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    t_q      <= t_d;
    res_q[0] <= res_d[0];
    res_q[1] <= res_d[1];
    diff_q   <= diff_d;
    up_q     <= up_d;
  end

  aipd_ser_mul #(
    .A_BITS(NW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  aipd_out_fifo #(
    .WIDTH(RW + 1)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fifo_push),
    .push_data_i(fifo_in),
    .full_o     (fifo_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (fifo_out)
  );

  assign {event_kind_o, strike_tick_o, confirm_tick_o, peak_level_o,
          floor_at_onset_o, threshold_at_onset_o, last_of_run_o} = fifo_out;

  // A result transaction is never written into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full) else $error("result pushed into full queue");

  // The noise floor never exceeds full scale.
  a_floor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_q <= ONE_F) else $error("noise floor above full scale");

  // A non-increasing timestamp yields exactly one pending result.
  a_error_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && err_now) |=> (state_q == S_FLUSH && n_q == 2'd1))
    else $error("timestamp error not staged as a single result");

  // The multiplier is never started during the flush state.
  a_mul_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> !mul_start) else $error("multiplier started during flush");

endmodule
